### design/rfppm_pkg.sv
package rfppm_pkg;

  // Payload widths
  localparam int unsigned VAL_W      = 14;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Parameter defaults
  localparam int unsigned AVG_DEPTH_DEF   = 25;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Register reset values
  localparam logic [GAIN_W-1:0] POWER_GAIN_RST = GAIN_W'(100);
  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RST = GAIN_W'(100);
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = HOLD_W'(75);

  // Divide by 100: products at or above SAT_LIMIT saturate, the rest fit
  // DIV_IN_W bits and divide exactly as (p * RECIP_100) >> RECIP_SHIFT.
  localparam int unsigned PCT_DIV     = 100;
  localparam int unsigned DIV_IN_W    = 21;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned SAT_LIMIT   = (int'(VAL_MAX) + 1) * PCT_DIV;
  localparam logic [RECIP_W-1:0] RECIP_100 =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_DIV) - 64'd1) / 64'(PCT_DIV));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_GAIN = 2'd0,
    CFG_DRIVE_GAIN = 2'd1,
    CFG_HOLD_TICKS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0]  held;
    logic [HOLD_W-1:0] count;
  } peak_t;

  // Peak hold: take a new maximum, else count down, else decay by one.
  function automatic peak_t peak_step(input logic [VAL_W-1:0] v, input peak_t cur,
                                      input logic [HOLD_W-1:0] reload);
    peak_t nxt;
    nxt = cur;
    if (v > cur.held) begin
      nxt.held  = v;
      nxt.count = reload;
    end else if (cur.count != '0) begin
      nxt.count = cur.count - 1'b1;
    end else if (cur.held != '0) begin
      nxt.held = cur.held - 1'b1;
    end
    return nxt;
  endfunction

endpackage

### design/rfppm_scale.sv
module rfppm_scale #(
  parameter int unsigned SAMPLE_BITS = rfppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             ld_prod_i,
  input  logic                             ld_scl_i,
  input  logic [SAMPLE_BITS-1:0]           sample_i,
  input  logic [rfppm_pkg::GAIN_W-1:0]     gain_i,
  output logic [rfppm_pkg::VAL_W-1:0]      scaled_o
);
  import rfppm_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int unsigned EXT_W  = (PROD_W > DIV_IN_W) ? PROD_W : DIV_IN_W;
  localparam int unsigned QUO_W  = DIV_IN_W + RECIP_W;

  logic [PROD_W-1:0] prod_q;
  logic [EXT_W-1:0]  prod_ext;
  logic [QUO_W-1:0]  quo_full;
  logic              sat;
  logic [VAL_W-1:0]  scaled_d, scaled_q;

  // stage 1: sample times gain
  always_ff @(posedge clk_i) begin
    if (ld_prod_i) begin
      prod_q <= PROD_W'(sample_i) * PROD_W'(gain_i);
    end
  end

  // stage 2: divide by 100 through the reciprocal, with saturation
  always_comb begin
    prod_ext = EXT_W'(prod_q);
    sat      = prod_ext >= EXT_W'(SAT_LIMIT);
    quo_full = QUO_W'(prod_ext[DIV_IN_W-1:0]) * QUO_W'(RECIP_100);
    scaled_d = sat ? VAL_MAX : quo_full[RECIP_SHIFT +: VAL_W];
  end

  always_ff @(posedge clk_i) begin
    if (ld_scl_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

### design/rfppm_win_mem.sv
module rfppm_win_mem #(
  parameter int unsigned AVG_DEPTH = rfppm_pkg::AVG_DEPTH_DEF,
  parameter int unsigned PTR_W     = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [PTR_W-1:0]            rd_addr_i,
  input  logic                        wr_en_i,
  input  logic [PTR_W-1:0]            wr_addr_i,
  input  logic [rfppm_pkg::VAL_W-1:0] wr_data_i,
  output logic [rfppm_pkg::VAL_W-1:0] rd_data_o
);
  import rfppm_pkg::*;

  logic [VAL_W-1:0]     mem_q [AVG_DEPTH];
  logic [AVG_DEPTH-1:0] vld_q;
  logic [VAL_W-1:0]     rdata_q;
  logic                 rvld_q;
  logic                 fwd_q;
  logic [VAL_W-1:0]     fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      rvld_q     <= vld_q[rd_addr_i];
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  // same-cycle write to the address being read wins
  assign rd_data_o = fwd_q ? fwd_data_q : (rvld_q ? rdata_q : '0);

endmodule

### design/rf_power_peak_hold_meter.sv
// RF power peak-hold meter.
//
// Config: write cfg_we_i with cfg_idx_i (0 power_gain, 1 drive_gain,
// 2 hold_ticks) and cfg_data_i; taken in the same cycle, no read-back.
// Write only while no request is in flight.
// Input: one request per tick (tx_on, forward, reflected, drive samples),
// accepted on in_valid_i && in_ready_o. Output: one result per request
// (held peaks after the update), taken on out_valid_o && out_ready_i.
// Throughput: one request per cycle while the output is not stalled; the
// forward average window is a one-port-read, one-port-write memory, read
// as a request leaves s2 and written as it leaves s3, with a bypass for a
// write to the entry being read.
// Stall: each of the six stages moves when the next is free, so requests
// keep flowing in while a result waits; after six requests pile up behind
// a stalled receiver in_ready_o drops.
// Reset: registers back to 100 / 100 / 75, peaks, counters, window sum and
// pointer cleared; window entries carry a valid bit and read as zero until
// written, so there is no clearing pass.
module rf_power_peak_hold_meter #(
  parameter int unsigned AVG_DEPTH   = rfppm_pkg::AVG_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = rfppm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config
  input  logic                             cfg_we_i,
  input  logic [rfppm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rfppm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request in
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             tx_on_i,
  input  logic [SAMPLE_BITS-1:0]           fwd_sample_i,
  input  logic [SAMPLE_BITS-1:0]           rfl_sample_i,
  input  logic [SAMPLE_BITS-1:0]           drv_sample_i,
  // result out
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rfppm_pkg::VAL_W-1:0]      fwd_peak_o,
  output logic [rfppm_pkg::VAL_W-1:0]      rfl_peak_o,
  output logic [rfppm_pkg::VAL_W-1:0]      drv_peak_o
);
  import rfppm_pkg::*;

  // window geometry; sum < AVG_DEPTH * 2^VAL_W fits SUM_W bits
  localparam int unsigned DW      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned PTR_W   = DW;
  localparam int unsigned SUM_W   = VAL_W + DW;
  // sum / AVG_DEPTH as (sum * AVG_RECIP) >> AVG_SHIFT, exact over SUM_W bits
  localparam int unsigned AVG_SHIFT = SUM_W + DW;
  localparam int unsigned RCP_W     = SUM_W + 2;
  localparam int unsigned APROD_W   = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RECIP =
    RCP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVG_DEPTH - 1);

  // config registers
  logic [GAIN_W-1:0] power_gain_q, drive_gain_q;
  logic [HOLD_W-1:0] hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_gain_q <= POWER_GAIN_RST;
      drive_gain_q <= DRIVE_GAIN_RST;
      hold_ticks_q <= HOLD_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POWER_GAIN: power_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_DRIVE_GAIN: drive_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i[HOLD_W-1:0];
        default: ; // unknown index ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage control: s1 product, s2 scaled + window read, s3 sum update,
  // s4 average, s5 peak update into the output register (s6)
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic acc, en1, en2, en3, en4, en5;

  assign rdy6 = !v6_q || out_ready_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign acc = in_valid_i && rdy1;
  assign en1 = v1_q && rdy2;
  assign en2 = v2_q && rdy3;
  assign en3 = v3_q && rdy4;
  assign en4 = v4_q && rdy5;
  assign en5 = v5_q && rdy6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v6_q;

  // tx flag rides along
  logic s1_tx_q, s2_tx_q, s3_tx_q, s4_tx_q, s5_tx_q;

  always_ff @(posedge clk_i) begin
    if (acc) s1_tx_q <= tx_on_i;
    if (en1) s2_tx_q <= s1_tx_q;
    if (en2) s3_tx_q <= s2_tx_q;
    if (en3) s4_tx_q <= s3_tx_q;
    if (en4) s5_tx_q <= s4_tx_q;
  end

  // ---------------------------------------------------------------------
  // s1/s2: scaling, one unit per channel
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0] fwd_scl, rfl_scl, drv_scl;

  rfppm_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scl_fwd (
    .clk_i     (clk_i),
    .ld_prod_i (acc),
    .ld_scl_i  (en1),
    .sample_i  (fwd_sample_i),
    .gain_i    (power_gain_q),
    .scaled_o  (fwd_scl)
  );

  rfppm_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scl_rfl (
    .clk_i     (clk_i),
    .ld_prod_i (acc),
    .ld_scl_i  (en1),
    .sample_i  (rfl_sample_i),
    .gain_i    (power_gain_q),
    .scaled_o  (rfl_scl)
  );

  rfppm_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scl_drv (
    .clk_i     (clk_i),
    .ld_prod_i (acc),
    .ld_scl_i  (en1),
    .sample_i  (drv_sample_i),
    .gain_i    (drive_gain_q),
    .scaled_o  (drv_scl)
  );

  // ---------------------------------------------------------------------
  // s2 -> s3: window read at the pointer, pointer advance on tx requests
  // ---------------------------------------------------------------------
  logic [PTR_W-1:0] ptr_q;
  logic [PTR_W-1:0] s3_addr_q;
  logic [VAL_W-1:0] s3_f_q, s3_r_q, s3_d_q;
  logic             rd_en, wr_en;
  logic [VAL_W-1:0] win_old;

  assign rd_en = en2 && s2_tx_q;
  assign wr_en = en3 && s3_tx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (rd_en) begin
      ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s3_addr_q <= ptr_q;
      s3_f_q    <= fwd_scl;
      s3_r_q    <= rfl_scl;
      s3_d_q    <= drv_scl;
    end
  end

  rfppm_win_mem #(.AVG_DEPTH(AVG_DEPTH), .PTR_W(PTR_W)) u_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (s3_addr_q),
    .wr_data_i (s3_f_q),
    .rd_data_o (win_old)
  );

  // ---------------------------------------------------------------------
  // s3: running sum read-modify-write, new sample into the window
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q, sum_d, s4_sum_q;
  logic [VAL_W-1:0] s4_r_q, s4_d_q;

  assign sum_d = sum_q - SUM_W'(win_old) + SUM_W'(s3_f_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (wr_en) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s4_sum_q <= sum_d;
      s4_r_q   <= s3_r_q;
      s4_d_q   <= s3_d_q;
    end
  end

  // ---------------------------------------------------------------------
  // s4: average = sum / AVG_DEPTH
  // ---------------------------------------------------------------------
  logic [APROD_W-1:0] avg_prod;
  logic [VAL_W-1:0]   s5_avg_q, s5_r_q, s5_d_q;

  assign avg_prod = APROD_W'(s4_sum_q) * APROD_W'(AVG_RECIP);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s5_avg_q <= avg_prod[AVG_SHIFT +: VAL_W];
      s5_r_q   <= s4_r_q;
      s5_d_q   <= s4_d_q;
    end
  end

  // ---------------------------------------------------------------------
  // s5: peak hold; the held values double as the output register
  // ---------------------------------------------------------------------
  peak_t fwd_q, rfl_q, drv_q;
  peak_t fwd_d, rfl_d, drv_d;

  always_comb begin
    drv_d = peak_step(s5_d_q, drv_q, hold_ticks_q);
    if (s5_tx_q) begin
      fwd_d = peak_step(s5_avg_q, fwd_q, hold_ticks_q);
      rfl_d = peak_step(s5_r_q, rfl_q, hold_ticks_q);
    end else begin
      // receive: peaks cleared, counters kept
      fwd_d      = fwd_q;
      fwd_d.held = '0;
      rfl_d      = rfl_q;
      rfl_d.held = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rfl_q <= '0;
      drv_q <= '0;
    end else if (en5) begin
      fwd_q <= fwd_d;
      rfl_q <= rfl_d;
      drv_q <= drv_d;
    end
  end

  assign fwd_peak_o = fwd_q.held;
  assign rfl_peak_o = rfl_q.held;
  assign drv_peak_o = drv_q.held;

endmodule

### design/rfppm_checker.sv
module rfppm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rfppm_pkg::VAL_W-1:0] fwd_peak_o,
  input logic [rfppm_pkg::VAL_W-1:0] rfl_peak_o,
  input logic [rfppm_pkg::VAL_W-1:0] drv_peak_o
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // and keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(fwd_peak_o) && $stable(rfl_peak_o) && $stable(drv_peak_o))
    else $error("result changed while stalled");

  // requests are refused only when the pipeline is backed up to a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused with output free");

  // no result appears right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result right after reset");

endmodule

bind rf_power_peak_hold_meter rfppm_checker u_rfppm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .fwd_peak_o  (fwd_peak_o),
  .rfl_peak_o  (rfl_peak_o),
  .drv_peak_o  (drv_peak_o)
);

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rfppm_pkg::*;

  localparam int unsigned WIN_DEPTH    = AVG_DEPTH_DEF;
  localparam int unsigned RAW_W        = SAMPLE_BITS_DEF;
  localparam int unsigned RAW_MAX      = (1 << RAW_W) - 1;
  localparam int unsigned GAP_MAX      = 17;
  // Settle time after draining, longer than the pipeline depth.
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_TICKS = 1100;
  localparam int unsigned MISS_SHOWN   = 10;
  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic             tx_on;
    logic [RAW_W-1:0] fwd;
    logic [RAW_W-1:0] rfl;
    logic [RAW_W-1:0] drv;
  } tick_t;

  typedef struct packed {
    logic [VAL_W-1:0] fwd;
    logic [VAL_W-1:0] rfl;
    logic [VAL_W-1:0] drv;
  } reading_t;

  // Sample profiles for one run of ticks.
  typedef enum int {
    SHAPE_NOISE,
    SHAPE_LEVEL,
    SHAPE_PULSE,
    SHAPE_RAMP
  } shape_e;

  // ---------------------------------------------------------------------------
  // DUT signals, all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  tx_on_i      = 1'b0;
  logic [RAW_W-1:0]      fwd_sample_i = '0;
  logic [RAW_W-1:0]      rfl_sample_i = '0;
  logic [RAW_W-1:0]      drv_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [VAL_W-1:0]      fwd_peak_o;
  logic [VAL_W-1:0]      rfl_peak_o;
  logic [VAL_W-1:0]      drv_peak_o;

  always #4 clk_i = ~clk_i;

  rf_power_peak_hold_meter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tx_on_i      (tx_on_i),
    .fwd_sample_i (fwd_sample_i),
    .rfl_sample_i (rfl_sample_i),
    .drv_sample_i (drv_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fwd_peak_o   (fwd_peak_o),
    .rfl_peak_o   (rfl_peak_o),
    .drv_peak_o   (drv_peak_o)
  );

  // ---------------------------------------------------------------------------
  // Meter predictor: registers, averaging window and the three peak holds
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] pwr_gain    = POWER_GAIN_RST;
  logic [GAIN_W-1:0] drv_gain    = DRIVE_GAIN_RST;
  logic [HOLD_W-1:0] hold_reload = HOLD_TICKS_RST;

  logic [VAL_W-1:0]  win_mem [WIN_DEPTH] = '{default: '0};
  int unsigned       win_ptr = 0;
  logic [18:0]       win_sum = '0;
  peak_t             fwd_pk  = '0;
  peak_t             rfl_pk  = '0;
  peak_t             drv_pk  = '0;

  tick_t       tick_q[$];     // requests waiting for the driver
  reading_t    reading_q[$];  // predicted peaks, oldest first
  int unsigned miss_cnt = 0;

  // Idle control per phase: calm means no gaps on that side.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic int unsigned draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Percent scaling, truncating, saturated at the 14-bit ceiling.
  function automatic logic [VAL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw,
                                                 input logic [GAIN_W-1:0] gain);
    int unsigned prod;
    prod = (32'(raw) * 32'(gain)) / PCT_DIV;
    if (prod > 32'(VAL_MAX)) prod = 32'(VAL_MAX);
    return VAL_W'(prod);
  endfunction

  // Peak hold: new max reloads the counter, else count down, else decay.
  function automatic peak_t hold_peak(input logic [VAL_W-1:0] v, input peak_t pk);
    peak_t res;
    res = pk;
    if (v > pk.held) begin
      res.held  = v;
      res.count = hold_reload;
    end else if (pk.count != 0) begin
      res.count = pk.count - 1'b1;
    end else if (pk.held != 0) begin
      res.held = pk.held - 1'b1;
    end
    return res;
  endfunction

  // Advance the predictor by one accepted request and queue the expected peaks.
  task automatic meter_tick(input tick_t t);
    logic [VAL_W-1:0] f_val;
    logic [VAL_W-1:0] r_val;
    reading_t         rd;
    if (t.tx_on) begin
      f_val = scale_raw(t.fwd, pwr_gain);
      // sum stays nonnegative overall; intermediate wrap is harmless
      win_sum = win_sum - win_mem[win_ptr] + f_val;
      win_mem[win_ptr] = f_val;
      win_ptr = (win_ptr + 1 == WIN_DEPTH) ? 0 : win_ptr + 1;
      f_val = VAL_W'(win_sum / WIN_DEPTH);
      r_val = scale_raw(t.rfl, pwr_gain);
      fwd_pk = hold_peak(f_val, fwd_pk);
      rfl_pk = hold_peak(r_val, rfl_pk);
    end else begin
      // receive tick: peaks cleared, counters and window untouched
      fwd_pk.held = '0;
      rfl_pk.held = '0;
    end
    drv_pk = hold_peak(scale_raw(t.drv, drv_gain), drv_pk);
    rd.fwd = fwd_pk.held;
    rd.rfl = rfl_pk.held;
    rd.drv = drv_pk.held;
    reading_q.push_back(rd);
  endtask

  task automatic report_miss(input string msg);
    miss_cnt++;
    if (miss_cnt <= MISS_SHOWN) $display("MISMATCH: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops the request queue, holds valid until accepted, then idles
  // a random number of cycles before presenting the next request.
  // ---------------------------------------------------------------------------
  tick_t       cur_tick = '0;
  bit          tx_busy  = 1'b0;
  int unsigned tx_wait  = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        meter_tick(cur_tick);
        tx_busy = 1'b0;
        tx_wait = draw_gap(tx_calm);
      end else if (!tx_busy && tx_wait > 0) begin
        tx_wait--;
      end
      if (!tx_busy && tx_wait == 0 && tick_q.size() != 0) begin
        cur_tick = tick_q.pop_front();
        tx_busy  = 1'b1;
      end
      in_valid_i   <= tx_busy;
      tx_on_i      <= cur_tick.tx_on;
      fwd_sample_i <= cur_tick.fwd;
      rfl_sample_i <= cur_tick.rfl;
      drv_sample_i <= cur_tick.drv;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction and
  // stalls ready for a random count after every accepted result.
  // ---------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  reading_t    got_rd;
  reading_t    want_rd;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_rd = '{fwd: fwd_peak_o, rfl: rfl_peak_o, drv: drv_peak_o};
        if (reading_q.size() == 0) begin
          report_miss($sformatf("unexpected result fwd=%0d rfl=%0d drv=%0d",
                                got_rd.fwd, got_rd.rfl, got_rd.drv));
        end else begin
          want_rd = reading_q.pop_front();
          if (got_rd.fwd != want_rd.fwd || got_rd.rfl != want_rd.rfl ||
              got_rd.drv != want_rd.drv) begin
            report_miss($sformatf(
              "fwd exp %0d got %0d, rfl exp %0d got %0d, drv exp %0d got %0d",
              want_rd.fwd, got_rd.fwd, want_rd.rfl, got_rd.rfl,
              want_rd.drv, got_rd.drv));
          end
        end
        rx_wait = draw_gap(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input logic tx, input int unsigned f, input int unsigned r,
                            input int unsigned d);
    tick_q.push_back('{tx_on: tx, fwd: RAW_W'(f), rfl: RAW_W'(r), drv: RAW_W'(d)});
  endtask

  function automatic int unsigned ramp_val(input int unsigned b, input int unsigned k);
    return (b + 9 * k > RAW_MAX) ? RAW_MAX : b + 9 * k;
  endfunction

  // One run of ticks with a common transmit flag and sample profile.
  task automatic queue_run(input logic tx, input int unsigned len, input shape_e shp);
    int unsigned bf;
    int unsigned br;
    int unsigned bd;
    int unsigned k;
    bf = $urandom_range(0, RAW_MAX);
    br = $urandom_range(0, RAW_MAX);
    bd = $urandom_range(0, RAW_MAX);
    for (k = 0; k < len; k++) begin
      case (shp)
        SHAPE_NOISE: begin
          queue_tick(1'($urandom), $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX),
                     $urandom_range(0, RAW_MAX));
        end
        SHAPE_LEVEL: begin
          queue_tick(tx, bf, br, bd);
        end
        SHAPE_PULSE: begin
          // one spike then low levels, so hold and decay get exercised
          if (k == 0) queue_tick(tx, bf, br, bd);
          else queue_tick(tx, $urandom_range(0, bf / 8), $urandom_range(0, br / 8),
                          $urandom_range(0, bd / 8));
        end
        default: begin
          queue_tick(tx, ramp_val(bf, k), ramp_val(br, k), ramp_val(bd, k));
        end
      endcase
    end
  endtask

  // Registers only change with the pipe empty; the spare index is hit too.
  task automatic set_regs(input logic [CFG_DATA_W-1:0] pg, input logic [CFG_DATA_W-1:0] dg,
                          input logic [CFG_DATA_W-1:0] hd);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_POWER_GAIN;
    cfg_data_i <= pg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DRIVE_GAIN;
    cfg_data_i <= dg;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HOLD_TICKS;
    cfg_data_i <= hd;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SPARE;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pwr_gain    = pg;
    drv_gain    = dg;
    hold_reload = hd[HOLD_W-1:0];
  endtask

  // Wait until every request went through and every result came back.
  task automatic drain();
    while (tick_q.size() != 0 || tx_busy || reading_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(RAW_MAX);
      2:       return CFG_DATA_W'(PCT_DIV);
      3:       return CFG_DATA_W'($urandom_range(1, 20));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Hold value with random bits above the 8-bit register, which must be dropped.
  function automatic logic [CFG_DATA_W-1:0] pick_hold();
    logic [HOLD_W-1:0] h;
    case ($urandom_range(0, 5))
      0:       h = '0;
      1:       h = '1;
      2:       h = HOLD_TICKS_RST;
      3:       h = HOLD_W'($urandom_range(1, 6));
      default: h = HOLD_W'($urandom);
    endcase
    return {2'($urandom), h};
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_done;
    int unsigned phase_left;
    int unsigned len;
    logic        run_tx;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: reset defaults, sample extremes, receive ticks in between.
    queue_tick(1'b1, RAW_MAX, RAW_MAX, RAW_MAX);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b0, RAW_MAX, RAW_MAX, RAW_MAX);
    queue_tick(1'b1, RAW_MAX, 0, 512);
    queue_tick(1'b1, 0, RAW_MAX, 0);
    queue_tick(1'b0, 0, 0, 0);
    queue_tick(1'b1, 1, 1, 1);
    queue_tick(1'b1, 512, 511, RAW_MAX);
    queue_tick(1'b1, 682, 341, 0);
    drain();

    // Max power gain, zero drive gain, hold written all ones (masks to 255).
    set_regs(CFG_DATA_W'(RAW_MAX), '0, '1);
    queue_tick(1'b1, RAW_MAX, RAW_MAX, RAW_MAX);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b0, 0, 0, RAW_MAX);
    queue_tick(1'b1, RAW_MAX, 1, 0);
    drain();

    // Zero power gain, max drive gain, hold masks to zero: decay right away.
    set_regs('0, CFG_DATA_W'(RAW_MAX), 10'h300);
    queue_tick(1'b1, RAW_MAX, RAW_MAX, RAW_MAX);
    queue_tick(1'b1, RAW_MAX, RAW_MAX, 0);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b0, RAW_MAX, RAW_MAX, RAW_MAX);
    drain();

    // Smallest nonzero settings.
    set_regs(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1));
    queue_tick(1'b1, RAW_MAX, RAW_MAX, RAW_MAX);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b1, 0, 0, 0);
    queue_tick(1'b1, 0, 0, 0);
    drain();

    // Random phases: new settings each phase, mostly transmit runs with
    // shaped samples, short receive runs and noise mixed in.
    random_done = 0;
    while (random_done < RANDOM_TICKS) begin
      set_regs(pick_gain(), pick_gain(), pick_hold());
      tx_calm    = ($urandom_range(0, 3) == 0);
      rx_calm    = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(40, 150);
      while (phase_left > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          run_tx = 1'b0;
          len    = $urandom_range(1, 4);
        end else begin
          run_tx = 1'b1;
          len    = $urandom_range(1, 40);
        end
        if (len > phase_left) len = phase_left;
        queue_run(run_tx, len, shape_e'($urandom_range(0, 3)));
        phase_left  -= len;
        random_done += len;
      end
      drain();
    end

    if (miss_cnt == 0 && reading_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
